FILE: hw/rtl/cad_pkg.sv
// Types, constants and helper functions shared by the date-offset block.
package cad_pkg;

	localparam logic [11:0] FIRST_YEAR = 12'd1901;
	localparam logic [11:0] LAST_YEAR  = 12'd2099;
	// last year relative to the first one
	localparam logic [7:0]  YEAR_SPAN  = 8'd198;
	localparam logic [16:0] SPAN_DAYS  = 17'd72684;
	localparam logic [3:0]  LAST_MONTH0 = 4'd11;
	localparam logic [8:0]  DAYS_YEAR  = 9'd365;
	localparam logic [4:0]  FEB_BASE   = 5'd28;
	// weekday remainder of day index 0 (a Tuesday, with Sunday as remainder 0)
	localparam logic [2:0]  WD_EPOCH   = 3'd2;

	typedef struct packed {
		logic [4:0]  start_day;
		logic [3:0]  start_month;
		logic [11:0] start_year;
		logic [15:0] offset_days;
		logic [4:0]  hour_in;
		logic [5:0]  minute_in;
		logic [5:0]  second_in;
	} in_item_t;

	typedef struct packed {
		logic [4:0]  result_day;
		logic [3:0]  result_month;
		logic [11:0] result_year;
		logic [2:0]  week_day;
		logic [4:0]  hour_out;
		logic [5:0]  minute_out;
		logic [5:0]  second_out;
		logic        range_overflow;
	} out_item_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_SCALE,
		OP_MADD,
		OP_CLAMP,
		OP_YSTEP,
		OP_MSTEP,
		OP_FINISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic madd_done;
		logic ywalk_done;
		logic mwalk_done;
	} dp_sts_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCALE,
		S_MADD,
		S_CLAMP,
		S_YWALK,
		S_MWALK,
		S_FINISH
	} ctl_state_t;

	// length of zero-based month m0
	function automatic logic [4:0] month_len(input logic [3:0] m0, input logic leap);
		logic [4:0] len;
		case (m0)
			4'd1: begin
				len = leap ? 5'd29 : 5'd28;
			end
			4'd3, 4'd5, 4'd8, 4'd10: begin
				len = 5'd30;
			end
			default: begin
				len = 5'd31;
			end
		endcase
		return len;
	endfunction

	function automatic logic [2:0] mod7(input logic [5:0] v);
		logic [5:0] r;
		r = v;
		if (r >= 6'd56) r = r - 6'd56;
		if (r >= 6'd28) r = r - 6'd28;
		if (r >= 6'd14) r = r - 6'd14;
		if (r >= 6'd7)  r = r - 6'd7;
		return r[2:0];
	endfunction

endpackage

FILE: hw/rtl/cad_in_if.sv
// Input channel: start date, day offset and time of day.
interface cad_in_if;
	import cad_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/cad_out_if.sv
// Output channel: resulting date, weekday, time of day and overflow flag.
interface cad_out_if;
	import cad_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/cad_ctrl.sv
// Sequencer for the date-offset datapath and output valid flag.
module cad_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  cad_pkg::dp_sts_t sts,
	output cad_pkg::dp_cmd_t cmd
);
	import cad_pkg::*;

	ctl_state_t state_q, state_d;
	logic       out_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd.op   = OP_NONE;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_SCALE;
				end
			end
			S_SCALE: begin
				cmd.op  = OP_SCALE;
				state_d = S_MADD;
			end
			S_MADD: begin
				if (sts.madd_done) begin
					state_d = S_CLAMP;
				end else begin
					cmd.op = OP_MADD;
				end
			end
			S_CLAMP: begin
				cmd.op  = OP_CLAMP;
				state_d = S_YWALK;
			end
			S_YWALK: begin
				if (sts.ywalk_done) begin
					state_d = S_MWALK;
				end else begin
					cmd.op = OP_YSTEP;
				end
			end
			S_MWALK: begin
				if (sts.mwalk_done) begin
					state_d = S_FINISH;
				end else begin
					cmd.op = OP_MSTEP;
				end
			end
			S_FINISH: begin
				// wait until the output register is free
				if (!out_full_q || out_ready) begin
					cmd.op  = OP_FINISH;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_full_q <= 1'b0;
		end else if (cmd.op == OP_FINISH) begin
			out_full_q <= 1'b1;
		end else if (out_ready) begin
			out_full_q <= 1'b0;
		end
	end

	assign out_valid = out_full_q;

endmodule

FILE: hw/rtl/cad_dpath.sv
// Day-index datapath: forward sum, clamp, year and month walk, output register.
module cad_dpath #(
	parameter int OFFSET_BITS = 16
) (
	input  logic              clk,
	input  cad_pkg::dp_cmd_t  cmd,
	input  cad_pkg::in_item_t in_data,
	output cad_pkg::out_item_t out_data,
	output cad_pkg::dp_sts_t  sts
);
	import cad_pkg::*;

	// holds the largest start index plus the largest offset
	localparam int IDX_W = ((OFFSET_BITS > 17) ? OFFSET_BITS : 17) + 1;
	localparam logic [IDX_W-1:0] OFF_MASK = IDX_W'((64'd1 << OFFSET_BITS) - 64'd1);

	logic [IDX_W-1:0] idx_q;
	logic [7:0]       yoff_q;
	logic [7:0]       ycnt_q;
	logic [3:0]       mon_q;
	logic [3:0]       mcnt_q;
	logic [2:0]       wd_q;
	logic             ov_q;
	logic [4:0]       hour_q;
	logic [5:0]       minute_q;
	logic [5:0]       second_q;
	out_item_t        out_q;

	logic [4:0]       day_c;
	logic [3:0]       mon_c;
	logic [11:0]      year_c;
	logic [16:0]      year_days;
	logic             start_leap;
	logic             walk_leap;
	logic [4:0]       start_mlen;
	logic [4:0]       walk_mlen;
	logic [8:0]       walk_ylen;
	logic [2:0]       wd_final;

	always_comb begin
		day_c  = (in_data.start_day == 5'd0) ? 5'd1 : in_data.start_day;
		mon_c  = in_data.start_month;
		if (mon_c == 4'd0) mon_c = 4'd1;
		if (mon_c > 4'd12) mon_c = 4'd12;
		year_c = in_data.start_year;
		if (year_c < FIRST_YEAR) year_c = FIRST_YEAR;
		if (year_c > LAST_YEAR)  year_c = LAST_YEAR;
	end

	// year offset 3 mod 4 is a leap year (1904, 1908, ...)
	assign start_leap = (yoff_q[1:0] == 2'b11);
	assign walk_leap  = (ycnt_q[1:0] == 2'b11);
	assign start_mlen = month_len(mcnt_q, start_leap);
	assign walk_mlen  = month_len(mcnt_q, walk_leap);
	assign walk_ylen  = DAYS_YEAR + {8'd0, walk_leap};
	assign year_days  = 17'(yoff_q) * 17'(DAYS_YEAR);
	assign wd_final   = mod7(6'(wd_q) + {1'b0, idx_q[4:0]});

	assign sts.madd_done  = ({1'b0, mcnt_q} + 5'd1) >= {1'b0, mon_q};
	assign sts.ywalk_done = (ycnt_q >= YEAR_SPAN) || (idx_q < IDX_W'(walk_ylen));
	assign sts.mwalk_done = (mcnt_q >= LAST_MONTH0) || (idx_q < IDX_W'(walk_mlen));

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				idx_q    <= IDX_W'(day_c - 5'd1) + (IDX_W'(in_data.offset_days) & OFF_MASK);
				yoff_q   <= 8'(year_c - FIRST_YEAR);
				mon_q    <= mon_c;
				mcnt_q   <= 4'd0;
				hour_q   <= in_data.hour_in;
				minute_q <= in_data.minute_in;
				second_q <= in_data.second_in;
			end
			OP_SCALE: begin
				idx_q <= idx_q + IDX_W'(year_days) + IDX_W'(yoff_q >> 2);
			end
			OP_MADD: begin
				idx_q  <= idx_q + IDX_W'(start_mlen);
				mcnt_q <= mcnt_q + 4'd1;
			end
			OP_CLAMP: begin
				if (idx_q >= IDX_W'(SPAN_DAYS)) begin
					idx_q <= IDX_W'(SPAN_DAYS - 17'd1);
					ov_q  <= 1'b1;
				end else begin
					ov_q  <= 1'b0;
				end
				ycnt_q <= 8'd0;
				mcnt_q <= 4'd0;
				wd_q   <= WD_EPOCH;
			end
			OP_YSTEP: begin
				idx_q  <= idx_q - IDX_W'(walk_ylen);
				ycnt_q <= ycnt_q + 8'd1;
				// 365 days move the weekday by one, 366 by two
				wd_q   <= mod7(6'(wd_q) + 6'd1 + {5'd0, walk_leap});
			end
			OP_MSTEP: begin
				idx_q  <= idx_q - IDX_W'(walk_mlen);
				mcnt_q <= mcnt_q + 4'd1;
				wd_q   <= mod7(6'(wd_q) + 6'(walk_mlen - FEB_BASE));
			end
			OP_FINISH: begin
				out_q.result_day     <= idx_q[4:0] + 5'd1;
				out_q.result_month   <= mcnt_q + 4'd1;
				out_q.result_year    <= FIRST_YEAR + 12'(ycnt_q);
				out_q.week_day       <= wd_final + 3'd1;
				out_q.hour_out       <= hour_q;
				out_q.minute_out     <= minute_q;
				out_q.second_out     <= second_q;
				out_q.range_overflow <= ov_q;
			end
			default: begin
			end
		endcase
	end

	assign out_data = out_q;

endmodule

FILE: hw/rtl/calendar_add_days.sv
// Top level: adds a day offset to a date and gives the new date and weekday.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    start date, offset_days, time of day
//   out_ch   out  valid/ready    result date, week_day, time of day, range_overflow
//
// One item at a time. An item passes idle, scale, the start-month sum, clamp, the
// year walk, the month walk and finish. The sum adds one month before the start
// month per step (up to 11), the year walk takes off one whole year per step (up
// to 198) and the month walk one whole month per step (up to 11).
// The year walk in the datapath is the longest part of an item's work.
// A finished result sits in the output register; the next transfer is taken
// meanwhile and only the final write waits on a stalled output.
// Reset clears the sequencer and the output valid flag; no clearing pass.
module calendar_add_days #(
	parameter int OFFSET_BITS = 16
) (
	input logic      clk,
	input logic      arst_n,
	cad_in_if.sink   in_ch,
	cad_out_if.source out_ch
);
	import cad_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	cad_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	cad_dpath #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_dpath (
		.clk      (clk),
		.cmd      (cmd),
		.in_data  (in_ch.data),
		.out_data (out_ch.data),
		.sts      (sts)
	);

	// overflow saturates to the last representable date
	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.data.range_overflow |->
			out_ch.data.result_year == LAST_YEAR && out_ch.data.result_month == 4'd12 &&
			out_ch.data.result_day == 5'd31 && out_ch.data.week_day == 3'd5)
		else $error("overflow result is not the last date");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> !in_ch.ready)
		else $error("input taken while an item is in work");

	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_ch.data.week_day != 3'd0 && out_ch.data.result_day != 5'd0 &&
			out_ch.data.result_month != 4'd0 && out_ch.data.result_month <= 4'd12)
		else $error("result field out of range");

	a_walk_end: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_FINISH |-> sts.ywalk_done && sts.mwalk_done)
		else $error("result written before the walk ended");

endmodule

FILE: dv/calendar_add_days_check.sv
// Checker for calendar_add_days: watches both channels, predicts each result date and compares.
module calendar_add_days_check #(
	parameter int OFFSET_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	cad_in_if           in_mon,
	cad_out_if          out_mon,
	output int unsigned errors,
	output int unsigned pending,
	output int unsigned checked,
	output int unsigned overflows
);
	import cad_pkg::*;

	localparam int unsigned NORMAL_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	out_item_t expected_dates [$];

	function automatic int unsigned month_days(input int unsigned m0, input int unsigned yr);
		if (m0 == 1 && yr % 4 == 0) begin
			return 29;
		end
		return NORMAL_LEN[m0];
	endfunction

	function automatic int unsigned year_days(input int unsigned yr);
		return (yr % 4 == 0) ? 366 : 365;
	endfunction

	// date reached by adding the offset, plus weekday and pass-through time
	function automatic out_item_t shifted_date(input in_item_t it);
		int unsigned d;
		int unsigned m;
		int unsigned y;
		int unsigned idx;
		int unsigned k;
		out_item_t r;
		d = it.start_day;
		m = it.start_month;
		y = it.start_year;
		if (d < 1) d = 1;
		if (m < 1) m = 1;
		if (m > 12) m = 12;
		if (y < FIRST_YEAR) y = FIRST_YEAR;
		if (y > LAST_YEAR) y = LAST_YEAR;
		idx = (y - FIRST_YEAR) * 365 + (y - FIRST_YEAR) / 4;
		for (k = 0; k + 1 < m; k++) begin
			idx += month_days(k, y);
		end
		idx += (d - 1) + (int'(it.offset_days) & ((1 << OFFSET_BITS) - 1));
		r = '0;
		r.range_overflow = (idx >= SPAN_DAYS);
		if (r.range_overflow) idx = SPAN_DAYS - 1;
		// day index 0 is a Tuesday
		r.week_day = 3'((idx + 2) % 7 + 1);
		y = FIRST_YEAR;
		while (y < LAST_YEAR && idx >= year_days(y)) begin
			idx -= year_days(y);
			y++;
		end
		k = 0;
		while (k < 11 && idx >= month_days(k, y)) begin
			idx -= month_days(k, y);
			k++;
		end
		r.result_day   = 5'(idx + 1);
		r.result_month = 4'(k + 1);
		r.result_year  = 12'(y);
		r.hour_out     = it.hour_in;
		r.minute_out   = it.minute_in;
		r.second_out   = it.second_in;
		return r;
	endfunction

	task automatic report(input string msg);
		if (errors < 30) begin
			$display("MISMATCH @%0t: %s", $realtime, msg);
		end
		errors++;
	endtask

	task automatic check_field(input string name, input int unsigned got, input int unsigned want);
		if (got != want) begin
			report($sformatf("%s got %0d expected %0d", name, got, want));
		end
	endtask

	initial begin
		errors = 0;
		pending = 0;
		checked = 0;
		overflows = 0;
	end

	always @(posedge clk) begin
		out_item_t want;
		out_item_t got;
		if (arst_n) begin
			if (in_mon.valid && in_mon.ready) begin
				expected_dates.push_back(shifted_date(in_mon.data));
			end
			if (out_mon.valid && out_mon.ready) begin
				got = out_mon.data;
				if (expected_dates.size() == 0) begin
					report("result transfer with nothing expected");
				end else begin
					want = expected_dates.pop_front();
					check_field("result_day", got.result_day, want.result_day);
					check_field("result_month", got.result_month, want.result_month);
					check_field("result_year", got.result_year, want.result_year);
					check_field("week_day", got.week_day, want.week_day);
					check_field("hour_out", got.hour_out, want.hour_out);
					check_field("minute_out", got.minute_out, want.minute_out);
					check_field("second_out", got.second_out, want.second_out);
					check_field("range_overflow", got.range_overflow, want.range_overflow);
					checked++;
					if (want.range_overflow) overflows++;
				end
			end
			pending = expected_dates.size();
		end
	end
endmodule

FILE: dv/calendar_add_days_test.sv
// Testbench top for calendar_add_days: clock, reset, stimulus, output stalls and verdict.
module calendar_add_days_test;
	import cad_pkg::*;

	localparam int OFFSET_BITS = 16;
	localparam int RANDOM_ITEMS = 1425;
	localparam int unsigned LIMIT = 1500000;

	logic clk;
	logic arst_n;
	int unsigned cycles;
	int unsigned sent;
	int unsigned errors;
	int unsigned pending;
	int unsigned checked;
	int unsigned overflows;
	bit in_burst;
	bit out_burst;

	cad_in_if in_ch ();
	cad_out_if out_ch ();

	calendar_add_days #(.OFFSET_BITS(OFFSET_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	calendar_add_days_check #(.OFFSET_BITS(OFFSET_BITS)) chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_mon(in_ch),
		.out_mon(out_ch),
		.errors(errors),
		.pending(pending),
		.checked(checked),
		.overflows(overflows)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial cycles = 0;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic in_item_t mk(input int d, input int m, input int y, input int off,
			input int h, input int mi, input int s);
		in_item_t it;
		it.start_day   = 5'(d);
		it.start_month = 4'(m);
		it.start_year  = 12'(y);
		it.offset_days = 16'(off);
		it.hour_in     = 5'(h);
		it.minute_in   = 6'(mi);
		it.second_in   = 6'(s);
		return it;
	endfunction

	// mostly legal dates with varied offsets, some late years to reach overflow, some raw noise
	function automatic in_item_t random_date();
		in_item_t it;
		int sel;
		it = mk($urandom_range(1, 28), $urandom_range(1, 12), $urandom_range(1901, 2099), 0,
			$urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59));
		if ($urandom_range(0, 9) == 0) it.start_day = 5'($urandom_range(29, 31));
		if ($urandom_range(0, 5) == 0) it.start_year = 12'($urandom_range(2080, 2099));
		sel = $urandom_range(0, 9);
		if (sel < 4) begin
			it.offset_days = 16'($urandom_range(0, 400));
		end else if (sel < 7) begin
			it.offset_days = 16'($urandom_range(0, 4095));
		end else if (sel < 9) begin
			it.offset_days = 16'($urandom);
		end else begin
			it.offset_days = 16'($urandom_range(60000, 65535));
		end
		if ($urandom_range(0, 9) < 3) begin
			it = in_item_t'($urandom) ^ (in_item_t'($urandom) << 32) ^ (in_item_t'($urandom) << 44);
		end
		return it;
	endfunction

	task automatic send_date(input in_item_t it);
		int gap;
		if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
		gap = in_burst ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= it;
		do @(posedge clk); while (!in_ch.ready);
		sent++;
	endtask

	// output side: random stall before each transfer
	initial begin
		int stall;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
			stall = out_burst ? 0 : $urandom_range(0, 16);
			if (stall != 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
		end
	end

	initial begin
		in_item_t directed [$];
		sent = 0;
		in_burst = 1'b0;
		out_burst = 1'b0;
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		directed.push_back(mk(1, 1, 1901, 0, 0, 0, 0));
		directed.push_back(mk(31, 12, 2099, 0, 23, 59, 59));
		directed.push_back(mk(31, 12, 2099, 1, 12, 30, 30));
		directed.push_back(mk(1, 1, 1901, 65535, 1, 2, 3));
		directed.push_back(mk(31, 12, 2099, 65535, 4, 5, 6));
		// last day in range exactly, then one past it
		directed.push_back(mk(1, 1, 1921, 65378, 7, 8, 9));
		directed.push_back(mk(1, 1, 1921, 65379, 10, 11, 12));
		directed.push_back(mk(0, 5, 1950, 10, 13, 14, 15));
		directed.push_back(mk(15, 0, 1960, 0, 16, 17, 18));
		directed.push_back(mk(15, 13, 1970, 0, 19, 20, 21));
		directed.push_back(mk(15, 15, 1980, 0, 22, 23, 24));
		directed.push_back(mk(10, 6, 0, 100, 0, 25, 26));
		directed.push_back(mk(10, 6, 1900, 0, 1, 27, 28));
		directed.push_back(mk(10, 6, 2100, 0, 2, 29, 30));
		directed.push_back(mk(10, 6, 4095, 0, 3, 31, 32));
		directed.push_back(mk(31, 2, 1901, 0, 4, 33, 34));
		directed.push_back(mk(31, 4, 1999, 0, 5, 35, 36));
		directed.push_back(mk(29, 2, 2000, 0, 6, 37, 38));
		directed.push_back(mk(28, 2, 1901, 1, 7, 39, 40));
		directed.push_back(mk(28, 2, 1904, 1, 8, 41, 42));
		directed.push_back(mk(31, 12, 1903, 1, 9, 43, 44));
		directed.push_back(mk(1, 3, 2012, 0, 31, 63, 63));
		directed.push_back(mk(31, 15, 4095, 65535, 31, 63, 63));
		directed.push_back(mk(0, 0, 0, 0, 0, 0, 0));
		foreach (directed[i]) send_date(directed[i]);

		repeat (RANDOM_ITEMS) send_date(random_date());
		in_ch.valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);

		$display("Sent %0d dates (%0d directed), checked %0d results, %0d of them overflowed.",
			sent, directed.size(), checked, overflows);
		$display("Mismatches: %0d", errors);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
